// ===== src/sm3_pkg.sv =====
// SM3 hash engine package: IV, round constants, permutation helpers and
// front-to-back queue entry type. No dependencies.
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;

  localparam logic [255:0] SM3_IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

  typedef struct packed {
    logic [31:0] word;
    logic        block_end;
    logic        msg_end;
  } sm3_req_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== src/sm3_front.sv =====
// SM3 front end: accepts message words, counts bits, pads the last word
// and emits a word stream with block and message marks. Uses sm3_pkg.
module sm3_front
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_word,
  input  logic [2:0]  in_count,
  input  logic        in_last,
  output logic        q_valid,
  input  logic        q_ready,
  output sm3_req_t    q_data
);

  typedef enum logic [3:0] {
    S_TAKE = 4'b0001,
    S_MARK = 4'b0010,
    S_ZERO = 4'b0100,
    S_LEN  = 4'b1000
  } fstate_t;

  fstate_t     state, state_next;
  logic [63:0] message_bits, message_bits_next;
  logic [3:0]  word_position, word_position_next;
  logic        len_low, len_low_next;
  logic [2:0]  cnt;
  logic [31:0] mask, marker;

  assign cnt = (in_count > 3'd4) ? 3'd4 : in_count;

  always_comb begin
    unique case (cnt)
      3'd0:    begin mask = 32'h0;        marker = 32'h80000000; end
      3'd1:    begin mask = 32'hff000000; marker = 32'h00800000; end
      3'd2:    begin mask = 32'hffff0000; marker = 32'h00008000; end
      3'd3:    begin mask = 32'hffffff00; marker = 32'h00000080; end
      default: begin mask = 32'hffffffff; marker = 32'h0;        end
    endcase
  end

  assign in_ready = (state == S_TAKE) && q_ready;

  always_comb begin
    state_next         = state;
    message_bits_next  = message_bits;
    word_position_next = word_position;
    len_low_next       = len_low;
    q_valid            = 1'b0;
    q_data.word        = 32'h0;
    q_data.msg_end     = 1'b0;
    unique case (state)
      S_TAKE: begin
        q_valid = in_valid;
        if (!in_last) begin
          q_data.word = in_word;
        end else begin
          q_data.word = (in_word & mask) | marker;
        end
        if (in_valid && q_ready) begin
          if (!in_last) begin
            message_bits_next = message_bits + 64'd32;
          end else begin
            message_bits_next = message_bits + {58'd0, cnt, 3'd0};
            if (cnt == 3'd4) begin
              state_next = S_MARK;
            end else if (word_position == 4'd13) begin
              state_next = S_LEN;
            end else begin
              state_next = S_ZERO;
            end
          end
          word_position_next = word_position + 4'd1;
        end
      end
      S_MARK: begin
        q_valid     = 1'b1;
        q_data.word = 32'h80000000;
        if (q_ready) begin
          word_position_next = word_position + 4'd1;
          state_next = (word_position == 4'd13) ? S_LEN : S_ZERO;
        end
      end
      S_ZERO: begin
        q_valid = 1'b1;
        if (q_ready) begin
          word_position_next = word_position + 4'd1;
          if (word_position == 4'd13) state_next = S_LEN;
        end
      end
      default: begin
        q_valid        = 1'b1;
        q_data.word    = len_low ? message_bits[31:0] : message_bits[63:32];
        q_data.msg_end = len_low;
        if (q_ready) begin
          word_position_next = word_position + 4'd1;
          len_low_next = !len_low;
          if (len_low) begin
            state_next         = S_TAKE;
            message_bits_next  = 64'd0;
            word_position_next = 4'd0;
          end
        end
      end
    endcase
    q_data.block_end = (word_position == 4'd15);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_TAKE;
      message_bits  <= 64'd0;
      word_position <= 4'd0;
      len_low       <= 1'b0;
    end else begin
      state         <= state_next;
      message_bits  <= message_bits_next;
      word_position <= word_position_next;
      len_low       <= len_low_next;
    end
  end

endmodule

// ===== src/sm3_queue.sv =====
// SM3 request queue: small FIFO between front end and compression core.
// Uses sm3_pkg for the entry type.
module sm3_queue
  import sm3_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  sm3_req_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output sm3_req_t rd_data
);

  sm3_req_t   mem [4];
  logic [1:0] wp, rp;
  logic [2:0] fill;
  logic       push, pop;

  assign wr_ready = (fill != 3'd4);
  assign rd_valid = (fill != 3'd0);
  assign rd_data  = mem[rp];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 2'd0;
      rp   <= 2'd0;
      fill <= 3'd0;
    end else begin
      if (push) wp <= wp + 2'd1;
      if (pop)  rp <= rp + 2'd1;
      fill <= fill + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

// ===== src/sm3_back.sv =====
// SM3 compression core: collects 16 words, runs 64 rounds one per cycle,
// folds into the chaining value and streams the digest. Uses sm3_pkg.
module sm3_back
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  sm3_req_t    q_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_index,
  output logic        out_last
);

  typedef enum logic [3:0] {
    B_LOAD  = 4'b0001,
    B_ROUND = 4'b0010,
    B_FOLD  = 4'b0100,
    B_OUT   = 4'b1000
  } bstate_t;

  bstate_t     state;
  logic [31:0] chain_value [8];
  logic [31:0] v [8];
  logic [31:0] w [16];
  logic [3:0]  load_pos;
  logic [5:0]  round;
  logic [2:0]  out_pos;
  logic        final_blk;
  logic [31:0] a12, ss1, ss2, tt1, tt2, ff, gg, tj, wnew, wj, wj4, xw;

  assign q_ready   = (state == B_LOAD);
  assign out_valid = (state == B_OUT);
  assign out_word  = chain_value[out_pos];
  assign out_index = out_pos;
  assign out_last  = (out_pos == 3'd7);

  // w[k] holds W[j+k]; W[j+16] shifts in at the top each round
  assign xw   = w[0] ^ w[7] ^ rotl(w[13], 5'd15);
  assign wnew = perm1(xw) ^ rotl(w[3], 5'd7) ^ w[10];
  assign wj   = w[0];
  assign wj4  = w[4];
  assign tj   = (round < 6'd16) ? T_LOW : T_HIGH;
  assign a12  = rotl(v[0], 5'd12);
  assign ss1  = rotl(a12 + v[4] + rotl(tj, round[4:0]), 5'd7);
  assign ss2  = ss1 ^ a12;
  always_comb begin
    if (round < 6'd16) begin
      ff = v[0] ^ v[1] ^ v[2];
      gg = v[4] ^ v[5] ^ v[6];
    end else begin
      ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
      gg = (v[4] & v[5]) | (~v[4] & v[6]);
    end
  end
  assign tt1 = ff + v[3] + ss2 + (wj ^ wj4);
  assign tt2 = gg + v[7] + ss1 + wj;

  always_ff @(posedge clk) begin
    if (state == B_LOAD && q_valid) begin
      w[load_pos] <= q_data.word;
    end else if (state == B_ROUND) begin
      for (int k = 0; k < 15; k++) w[k] <= w[k + 1];
      w[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LOAD) begin
      for (int k = 0; k < 8; k++) v[k] <= chain_value[k];
    end else if (state == B_ROUND) begin
      v[3] <= v[2];
      v[2] <= rotl(v[1], 5'd9);
      v[1] <= v[0];
      v[0] <= tt1;
      v[7] <= v[6];
      v[6] <= rotl(v[5], 5'd19);
      v[5] <= v[4];
      v[4] <= perm0(tt2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_LOAD;
      load_pos  <= 4'd0;
      round     <= 6'd0;
      out_pos   <= 3'd0;
      final_blk <= 1'b0;
      for (int k = 0; k < 8; k++) chain_value[k] <= SM3_IV[255 - 32*k -: 32];
    end else begin
      unique case (state)
        B_LOAD: begin
          if (q_valid) begin
            load_pos <= load_pos + 4'd1;
            if (q_data.block_end) begin
              state     <= B_ROUND;
              final_blk <= q_data.msg_end;
              round     <= 6'd0;
            end
          end
        end
        B_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= B_FOLD;
        end
        B_FOLD: begin
          for (int k = 0; k < 8; k++) chain_value[k] <= chain_value[k] ^ v[k];
          state   <= final_blk ? B_OUT : B_LOAD;
          out_pos <= 3'd0;
        end
        default: begin
          if (out_ready) begin
            out_pos <= out_pos + 3'd1;
            if (out_pos == 3'd7) begin
              state <= B_LOAD;
              for (int k = 0; k < 8; k++)
                chain_value[k] <= SM3_IV[255 - 32*k -: 32];
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== src/sm3_hash_engine_core.sv =====
// SM3 hash engine top level: front end, request queue, compression core.
// Throughput is set by the one-round-per-cycle compression unit, which takes
// no new words while it runs rounds, folds or streams the eight digest words.
// Synchronous active-high reset returns chaining value to the IV.
module sm3_hash_engine_core
  import sm3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // message_word[31:0], byte_count[34:32], zeros
  input  logic        s_tlast,   // last_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // digest_word[31:0], word_index[34:32], zeros
  output logic        m_tlast    // digest_last
);

  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  sm3_req_t fq_data, qb_data;
  logic [31:0] dw;
  logic [2:0]  di;

  sm3_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready),
    .in_word(s_tdata[31:0]), .in_count(s_tdata[34:32]), .in_last(s_tlast),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data));

  sm3_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data));

  sm3_back u_back (
    .clk, .rst,
    .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_word(dw), .out_index(di), .out_last(m_tlast));

  assign m_tdata = {5'd0, di, dw};

`ifndef SYNTHESIS
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7))) else $error("last flag");
  a_no_in_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !qb_ready) else $error("core loads while emitting");
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid &&
      m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)) else $error("index step");
`endif

endmodule
